// ----- rtl/core/bpfc_pkg.sv -----
// Shared types and constants for the bitmask pixel format converter.
// No dependencies; every other file in rtl/core uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bpfc_pkg;

  // Pipeline depth: three compute stages plus the output register
  localparam int unsigned NUM_STAGES = 4;

  // Pixel format codes
  typedef enum logic [1:0] {
    FMT_RGB0    = 2'd0,
    FMT_RGB1    = 2'd1,
    FMT_BITMASK = 2'd2,
    FMT_RSVD    = 2'd3
  } pix_fmt_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_RED_MASK     = 2'd1,
    CFG_GREEN_MASK   = 2'd2,
    CFG_BLUE_MASK    = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] RGB_MASK    = 32'h00FF_FFFF;
  localparam logic [31:0] ROUND_ADD   = 32'd127;
  // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_255   = 32'h8080_8081;
  localparam int unsigned RECIP_SHIFT = 39;
  localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

  // Per-stage load enables and valid bits from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // Field placement decoded from one channel mask
  typedef struct packed {
    logic [4:0] pos;
    logic [5:0] width;
    logic       full;
  } field_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpfc_mask_decode.sv -----
// Decodes one channel mask into field position, run width and full-word flag.
// Depends on bpfc_pkg for field_t.
`timescale 1ns / 1ps
`default_nettype none

module bpfc_mask_decode (
  input  wire logic [31:0]     mask,
  output bpfc_pkg::field_t     field
);

  logic [31:0] low_bit;
  logic [31:0] run_bits;
  logic [31:0] below_low;

  // Isolate the lowest set bit and the run of ones that starts there
  assign low_bit   = mask & (~mask + 32'd1);
  assign run_bits  = (mask ^ (mask + low_bit)) & mask;
  assign below_low = low_bit - 32'd1;

  // Count bits under the lowest one for the position, run bits for the width
  always_comb begin
    field.pos   = 5'($countones(below_low));
    field.width = 6'($countones(run_bits));
    field.full  = &mask;
  end

endmodule

`default_nettype wire

// ----- rtl/core/bpfc_chan_path.sv -----
// One color channel: mask decode, rescale to field width, divide by 255, place.
// Depends on bpfc_pkg and bpfc_mask_decode; stepped by the shared pipeline control.
`timescale 1ns / 1ps
`default_nettype none

module bpfc_chan_path (
  input  wire logic                clk,
  input  wire bpfc_pkg::pipe_ctl_t ctl,
  input  wire logic [7:0]          chan_value,
  input  wire logic [31:0]         chan_mask,
  output logic [31:0]              placed
);

  bpfc_pkg::field_t field;

  logic [7:0]              value_s1_r;
  bpfc_pkg::field_t        field_s1_r;
  logic [31:0]             scaled_s2_r;
  logic [4:0]              pos_s2_r;
  logic                    full_s2_r;
  logic [63:0]             prod_s3_r;
  logic [4:0]              pos_s3_r;
  logic                    full_s3_r;

  logic [31:0]             scaled_nxt;
  logic [bpfc_pkg::QUOT_W-1:0] quot;

  bpfc_mask_decode u_decode (
    .mask  (chan_mask),
    .field (field)
  );

  // v * (2^w - 1) + 127, all modulo 2^32
  assign scaled_nxt = ((32'(value_s1_r) << field_s1_r.width) - 32'(value_s1_r))
                      + bpfc_pkg::ROUND_ADD;

  // Stage 1: capture channel value and decoded field
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      value_s1_r <= chan_value;
      field_s1_r <= field;
    end
  end

  // Stage 2: rounded product
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      scaled_s2_r <= scaled_nxt;
      pos_s2_r    <= field_s1_r.pos;
      full_s2_r   <= field_s1_r.full;
    end
  end

  // Stage 3: reciprocal multiply for the divide by 255
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      prod_s3_r <= 64'(scaled_s2_r) * 64'(bpfc_pkg::RECIP_255);
      pos_s3_r  <= pos_s2_r;
      full_s3_r <= full_s2_r;
    end
  end

  // Shift the quotient into place; a zero mask clears it, an all-ones mask passes
  assign quot = prod_s3_r[63:bpfc_pkg::RECIP_SHIFT];

  always_comb begin
    if (full_s3_r) begin
      placed = chan_mask;
    end else begin
      placed = (32'(quot) << pos_s3_r) & chan_mask;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bpfc_pipe_ctrl.sv -----
// Valid bits and per-stage load enables for the converter pipeline.
// Depends on bpfc_pkg; a stage loads when it is empty or its successor moves.
`timescale 1ns / 1ps
`default_nettype none

module bpfc_pipe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             out_ready,
  output logic                  in_ready,
  output bpfc_pkg::pipe_ctl_t   ctl
);

  localparam int unsigned N = bpfc_pkg::NUM_STAGES;

  logic [N-1:0] valid_r;
  logic [N-1:0] valid_nxt;
  logic [N-1:0] rdy;
  logic [N-1:0] feed;

  // Ready ripples back from the output; a bubble lets earlier stages close up
  always_comb begin
    rdy[N-1] = ~valid_r[N-1] | out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = ~valid_r[k] | rdy[k+1];
    end
    feed = {valid_r[N-2:0], in_valid};
    for (int k = 0; k < N; k++) begin
      valid_nxt[k] = rdy[k] ? feed[k] : valid_r[k];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign ctl.load  = rdy;
  assign ctl.valid = valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/bitmask_pixel_format_converter.sv -----
// Top level of the bitmask pixel format converter: config registers, three
// channel paths and the output register. Depends on bpfc_pkg, bpfc_pipe_ctrl,
// bpfc_chan_path.
//
//   channel   ports                               direction
//   in        in_valid/in_ready, in_source_pixel  request in
//   out       out_valid/out_ready, out_converted_pixel  request out
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  register write in
//
// Takes one pixel per clock while out_ready allows; the stages are decode, rounded product,
// 32x32 reciprocal multiply for the divide by 255, and output register.
// Synchronous active-low reset clears the valid bits and the config registers to 0.
// A stall at out_ready backs up stage by stage; bubbles close up, nothing drops.
// Configuration writes are always accepted and take effect on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module bitmask_pixel_format_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_source_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_converted_pixel,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned LAST = bpfc_pkg::NUM_STAGES - 1;

  bpfc_pkg::pipe_ctl_t ctl;
  bpfc_pkg::pix_fmt_t  pixel_format_r;
  logic [31:0]         red_mask_r;
  logic [31:0]         green_mask_r;
  logic [31:0]         blue_mask_r;

  logic [23:0]         rgb_s1_r;
  logic [23:0]         rgb_s2_r;
  logic [23:0]         rgb_s3_r;
  logic [31:0]         converted_r;
  logic [31:0]         converted_nxt;

  logic [31:0]         red_placed;
  logic [31:0]         green_placed;
  logic [31:0]         blue_placed;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= bpfc_pkg::FMT_RGB0;
      red_mask_r     <= '0;
      green_mask_r   <= '0;
      blue_mask_r    <= '0;
    end else if (cfg_valid) begin
      unique case (bpfc_pkg::cfg_idx_t'(cfg_index))
        bpfc_pkg::CFG_PIXEL_FORMAT: pixel_format_r <= bpfc_pkg::pix_fmt_t'(cfg_data[1:0]);
        bpfc_pkg::CFG_RED_MASK:     red_mask_r     <= cfg_data;
        bpfc_pkg::CFG_GREEN_MASK:   green_mask_r   <= cfg_data;
        bpfc_pkg::CFG_BLUE_MASK:    blue_mask_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  bpfc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  bpfc_chan_path u_red (
    .clk        (clk),
    .ctl        (ctl),
    .chan_value (in_source_pixel[23:16]),
    .chan_mask  (red_mask_r),
    .placed     (red_placed)
  );

  bpfc_chan_path u_green (
    .clk        (clk),
    .ctl        (ctl),
    .chan_value (in_source_pixel[15:8]),
    .chan_mask  (green_mask_r),
    .placed     (green_placed)
  );

  bpfc_chan_path u_blue (
    .clk        (clk),
    .ctl        (ctl),
    .chan_value (in_source_pixel[7:0]),
    .chan_mask  (blue_mask_r),
    .placed     (blue_placed)
  );

  // Carry the pass-through word alongside the channel paths
  always_ff @(posedge clk) begin
    if (ctl.load[0]) rgb_s1_r <= in_source_pixel[23:0];
    if (ctl.load[1]) rgb_s2_r <= rgb_s1_r;
    if (ctl.load[2]) rgb_s3_r <= rgb_s2_r;
  end

  // Merge channels or pass RGB through
  always_comb begin
    case (pixel_format_r)
      bpfc_pkg::FMT_BITMASK: converted_nxt = red_placed | green_placed | blue_placed;
      default:               converted_nxt = {8'd0, rgb_s3_r};
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load[LAST]) converted_r <= converted_nxt;
  end

  assign out_valid           = ctl.valid[LAST];
  assign out_converted_pixel = converted_r;

`ifndef ASSERT_OFF
  // A full third stage with room downstream must reach the output
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.valid[LAST-1] && ctl.load[LAST] |=> out_valid)
    else $error("item lost between multiply stage and output");

  // Input back-pressure only when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&ctl.valid) && !out_ready)
    else $error("input stalled with room in the pipeline");

  // Pass-through results never carry the top byte
  a_pass_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $stable(pixel_format_r) && pixel_format_r != bpfc_pkg::FMT_BITMASK
    |-> out_converted_pixel[31:24] == 8'd0)
    else $error("pass-through result has nonzero top byte");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_bitmask_pixel_format_converter.sv -----
// Self-checking testbench for bitmask_pixel_format_converter: a directed table,
// then random pixel phases under changing formats and masks, with a pixel-level predictor.
// Depends on bpfc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_bitmask_pixel_format_converter;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RAND_PHASES  = 14;
  localparam int unsigned PHASE_PIXELS = 100;
  localparam int unsigned HOLDOFF_LEN  = 400;
  localparam int unsigned HOLDOFF_PHASE = 3;
  localparam logic [63:0] WORD_BITS_MASK = 64'hFFFF_FFFF;
  localparam logic [63:0] CHAN_FULL      = 64'd255;

  // One row of the directed script: a register write or a pixel request
  typedef struct packed {
    logic                 is_write;
    bpfc_pkg::cfg_idx_t   idx;
    logic [31:0]          data;
    logic                 known;
    logic [31:0]          want;
  } script_row_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_BUSY,
    SINK_ALTERNATE,
    SINK_SPARSE
  } sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_source_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_converted_pixel;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  bpfc_pkg::cfg_idx_t cfg_index = bpfc_pkg::CFG_PIXEL_FORMAT;
  logic [31:0] cfg_data = '0;

  // Register copies seen by the predictor
  bpfc_pkg::pix_fmt_t cur_format = bpfc_pkg::FMT_RGB0;
  logic [31:0] cur_red_mask = '0;
  logic [31:0] cur_green_mask = '0;
  logic [31:0] cur_blue_mask = '0;

  logic [31:0] pending_pixels [$];
  int unsigned errors = 0;
  int unsigned cycle = 0;
  int unsigned burst_left = 0;

  // Receiver stall state
  logic        holdoff_req = 1'b0;
  logic        holdoff_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned seg_left = 0;
  sink_mode_t  sink_mode = SINK_OPEN;

  script_row_t script [34] = '{
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'hA5C3_3C5A, 1'b1, 32'h00C3_3C5A},
    '{1'b1, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0000_0003, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'hFF12_3456, 1'b1, 32'h0012_3456},
    '{1'b1, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0000_0001, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h8080_8080, 1'b1, 32'h0080_8080},
    '{1'b1, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0000_0002, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{1'b1, bpfc_pkg::CFG_RED_MASK,     32'h0000_F800, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_GREEN_MASK,   32'h0000_07E0, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_BLUE_MASK,    32'h0000_001F, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h00FF_FFFF, 1'b1, 32'h0000_FFFF},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h00FF_0000, 1'b1, 32'h0000_F800},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h1234_5678, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_RED_MASK,     32'hFFFF_FFFF, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_GREEN_MASK,   32'h0000_0000, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_BLUE_MASK,    32'h0000_0000, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{1'b1, bpfc_pkg::CFG_RED_MASK,     32'h7FFF_FFFF, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_GREEN_MASK,   32'h0F0F_0000, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_BLUE_MASK,    32'h8000_0000, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h00FF_FFFF, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0001_7F80, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_RED_MASK,     32'h00FF_0000, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_GREEN_MASK,   32'h0000_FF00, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_BLUE_MASK,    32'h0000_00FF, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'hFFAB_CDEF, 1'b1, 32'h00AB_CDEF},
    '{1'b1, bpfc_pkg::CFG_RED_MASK,     32'hFFFF_0000, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_GREEN_MASK,   32'h00FF_FF00, 1'b0, 32'h0},
    '{1'b1, bpfc_pkg::CFG_BLUE_MASK,    32'h0000_FFFF, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h00FF_00FF, 1'b0, 32'h0},
    '{1'b0, bpfc_pkg::CFG_PIXEL_FORMAT, 32'h0080_8080, 1'b0, 32'h0}
  };

  bitmask_pixel_format_converter i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_source_pixel     (in_source_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_converted_pixel (out_converted_pixel),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Rescale one 8-bit channel into the field that the mask locates.
  // Only the lowest run of ones sets the width; the whole mask gates the result.
  function automatic logic [31:0] place_channel_field(input logic [7:0] v,
                                                      input logic [31:0] m);
    int unsigned lsb;
    int unsigned run;
    logic [63:0] ones;
    logic [63:0] acc;
    if (m == '0) return '0;
    lsb = 0;
    while (!m[lsb]) lsb++;
    run = 0;
    while (lsb + run < 32 && m[lsb + run]) run++;
    if (run >= 32) return m;
    ones = (64'd1 << run) - 64'd1;
    // product and rounding wrap at 32 bits before the divide
    acc = ({56'd0, v} * ones) & WORD_BITS_MASK;
    acc = (acc + {32'd0, bpfc_pkg::ROUND_ADD}) & WORD_BITS_MASK;
    acc = acc / CHAN_FULL;
    acc = (acc << lsb) & WORD_BITS_MASK;
    return acc[31:0] & m;
  endfunction

  function automatic logic [31:0] convert_pixel(input logic [31:0] px);
    if (cur_format == bpfc_pkg::FMT_BITMASK)
      return place_channel_field(px[23:16], cur_red_mask) |
             place_channel_field(px[15:8], cur_green_mask) |
             place_channel_field(px[7:0], cur_blue_mask);
    return px & bpfc_pkg::RGB_MASK;
  endfunction

  function automatic logic [31:0] rand_mask();
    int unsigned w;
    int unsigned lsb;
    logic [31:0] m;
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = '1;
      2: m = $urandom();
      default: begin
        // wide fields can make the product wrap
        w = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 31);
        lsb = $urandom_range(0, 32 - w);
        m = 32'(((64'd1 << w) - 64'd1) << lsb);
        if ($urandom_range(0, 4) == 0) m |= $urandom() & $urandom();
      end
    endcase
    return m;
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom();
    // push channels to their extremes now and then
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 5) == 0) p[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  // Offer one pixel request in bursts; hold it until accepted, then log the expectation
  task automatic send_pixel(input logic [31:0] px, input logic known, input logic [31:0] want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_source_pixel <= px;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(known ? want : convert_pixel(px));
  endtask

  // Drop the input, wait until every result is back, then write one register
  task automatic write_reg(input bpfc_pkg::cfg_idx_t idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpfc_pkg::CFG_PIXEL_FORMAT: cur_format = bpfc_pkg::pix_fmt_t'(data[1:0]);
      bpfc_pkg::CFG_RED_MASK:     cur_red_mask = data;
      bpfc_pkg::CFG_GREEN_MASK:   cur_green_mask = data;
      bpfc_pkg::CFG_BLUE_MASK:    cur_blue_mask = data;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus: reset, directed script, random phases, drain
  initial begin
    logic [31:0]        fmt_word;
    bpfc_pkg::pix_fmt_t code;
    bpfc_pkg::cfg_idx_t mask_regs [3];
    mask_regs = '{bpfc_pkg::CFG_RED_MASK, bpfc_pkg::CFG_GREEN_MASK, bpfc_pkg::CFG_BLUE_MASK};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_write)
        write_reg(script[i].idx, script[i].data);
      else
        send_pixel(script[i].data, script[i].known, script[i].want);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      // mostly bitmask; upper data bits of the format write are don't-care
      code = ($urandom_range(0, 9) < 6) ? bpfc_pkg::FMT_BITMASK :
                                          bpfc_pkg::pix_fmt_t'($urandom_range(0, 3));
      fmt_word = $urandom();
      fmt_word[1:0] = code;
      write_reg(bpfc_pkg::CFG_PIXEL_FORMAT, fmt_word);
      foreach (mask_regs[j]) begin
        if ($urandom_range(0, 3) != 0) write_reg(mask_regs[j], rand_mask());
      end
      if (phase == HOLDOFF_PHASE) holdoff_req <= 1'b1;
      for (int n = 0; n < PHASE_PIXELS; n++) send_pixel(rand_pixel(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4 * bpfc_pkg::NUM_STAGES) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stall patterns plus one long hold-off to back up the pipe
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holdoff_req && !holdoff_taken) begin
      holdoff_taken <= 1'b1;
      hold_left <= HOLDOFF_LEN;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(10, 120);
        sink_mode <= sink_mode_t'($urandom_range(0, 3));
      end else begin
        seg_left <= seg_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:      out_ready <= 1'b1;
        SINK_BUSY:      out_ready <= ($urandom_range(0, 3) != 0);
        SINK_ALTERNATE: out_ready <= cycle[0];
        SINK_SPARSE:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("converted_pixel: unexpected result %h", out_converted_pixel);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_converted_pixel !== want) begin
          $error("converted_pixel: expected %h, actual %h", want, out_converted_pixel);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
